[design/mnbt_pkg.sv]
// Package for the mutual nearest branch tracker.
// Holds shared widths, defaults and the register reset value; no dependencies.
package mnbt_pkg;

  localparam int MAX_POINTS_DEF     = 16;
  localparam int BRANCH_ID_BITS_DEF = 16;
  localparam int COORD_W            = 16;
  localparam int POINT_W            = 3 * COORD_W;
  localparam int SQ_W               = 2 * COORD_W;
  localparam int DIST_W             = SQ_W + 2;
  localparam int THR_W              = 32;
  localparam int INDEX_OUT_W        = 6;
  localparam int ID_OUT_W           = 16;
  localparam logic [THR_W-1:0] THR_RESET = 32'h4000_0000;

endpackage

[design/mnbt_ram.sv]
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies; read data holds while the read enable is low.
module mnbt_ram #(
  parameter int W  = 8,
  parameter int D  = 16,
  parameter int AW = (D > 1) ? $clog2(D) : 1
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[design/mutual_nearest_branch_tracker.sv]
// Mutual nearest neighbor branch tracker, top level.
// Depends on mnbt_pkg and mnbt_ram.
//
// Usage: points of one sample arrive on the input channel (in_valid/in_stall),
// one beat per point, with last_in_sample on the closing beat. sweep_start on
// a beat clears the previous sample and the branch counter first. While
// gathering, a beat is taken every cycle. After the closing beat, in_stall
// stays high while the sample is matched against the previous one, and one
// result beat per stored point leaves on the output channel (out_valid /
// out_stall) in point order, last_result on the final one.
// When matching, every distance goes through one four-stage distance
// pipeline fed from the point memories, one index at a time, and each
// result then passes a resolve state that reads the link table and the
// branch ids, and an emit state. With no previous sample, each result
// skips the distance scan and goes straight to the resolve state.
// The output register lets the next sample start loading while the final
// result waits. A stalled receiver holds the matcher at its next result.
// Reset returns to idle, empty samples, branch counter zero, threshold 2^30
// (squared distance); memories are not cleared. The configuration channel
// (cfg_valid/cfg_ready) is always ready, written only while idle (unenforced).
module mutual_nearest_branch_tracker
  import mnbt_pkg::*;
#(
  parameter int MAX_POINTS     = MAX_POINTS_DEF,
  parameter int BRANCH_ID_BITS = BRANCH_ID_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [mnbt_pkg::THR_W-1:0]      cfg_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [mnbt_pkg::COORD_W-1:0]    x_coord,
  input  logic [mnbt_pkg::COORD_W-1:0]    y_coord,
  input  logic [mnbt_pkg::COORD_W-1:0]    z_coord,
  input  logic                            point_present,
  input  logic                            last_in_sample,
  input  logic                            sweep_start,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [mnbt_pkg::INDEX_OUT_W-1:0] point_index,
  output logic [mnbt_pkg::ID_OUT_W-1:0]   branch_id,
  output logic                            new_branch,
  output logic                            branch_overflow,
  output logic                            sample_overflow,
  output logic                            last_result
);

  localparam int IW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CW = $clog2(MAX_POINTS + 1);
  localparam int BW = BRANCH_ID_BITS;

  typedef enum logic [4:0] {
    S_IDLE    = 5'b00001,
    S_SCAN    = 5'b00010,
    S_DRAIN   = 5'b00100,
    S_RESOLVE = 5'b01000,
    S_EMIT    = 5'b10000
  } state_t;

  state_t          state;
  logic [THR_W-1:0] thr;
  logic            cur_sel;
  logic [CW-1:0]   cur_count;
  logic [CW-1:0]   prev_count;
  logic [BW:0]     next_branch;
  logic            dropped;
  logic            pass2;
  logic [IW-1:0]   outer;
  logic [IW-1:0]   inner;

  logic            v0, v1, v2, v3;
  logic [IW-1:0]   t0, t1, t2, t3;
  logic [COORD_W-1:0] dx, dy, dz;
  logic [SQ_W-1:0] sx, sy, sz;
  logic [DIST_W-1:0] dsum;
  logic [DIST_W-1:0] best_d;
  logic [IW-1:0]   best_idx;

  logic [POINT_W-1:0] pt_rd [2];
  logic [BW-1:0]      id_rd [2];
  logic [IW-1:0]      near_rd;
  logic [POINT_W-1:0] cur_pt, prv_pt;
  logic [IW-1:0]      cur_addr, prv_addr, wr_idx;
  logic               in_acc, store_pt, near_we, out_load, drop_next;
  logic [CW-1:0]      inner_lim, outer_lim, cnt_base, cnt_after;
  logic               inner_last, outer_last, linked, fresh_ovf;
  logic [BW-1:0]      res_id;
  logic [BW+ID_OUT_W-1:0] res_id_ext;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign store_pt  = in_acc && point_present &&
                     (sweep_start || (cur_count < CW'(MAX_POINTS)));
  assign wr_idx    = sweep_start ? '0 : cur_count[IW-1:0];
  assign cnt_base  = sweep_start ? '0 : cur_count;
  assign cnt_after = store_pt ? cnt_base + CW'(1) : cnt_base;
  assign drop_next = (dropped && !sweep_start) || (point_present && !store_pt);

  assign cur_addr   = (state == S_IDLE) ? cur_count[IW-1:0] : (pass2 ? outer : inner);
  assign prv_addr   = pass2 ? inner : outer;
  assign cur_pt     = pt_rd[cur_sel];
  assign prv_pt     = pt_rd[~cur_sel];
  assign inner_lim  = pass2 ? prev_count : cur_count;
  assign outer_lim  = pass2 ? cur_count : prev_count;
  assign inner_last = (CW'(inner) + CW'(1)) == inner_lim;
  assign outer_last = (CW'(outer) + CW'(1)) == outer_lim;
  assign near_we    = (state == S_DRAIN) && !pass2 && !v0 && !v1 && !v2 && !v3;

  for (genvar k = 0; k < 2; k++) begin : g_bank
    mnbt_ram #(.W(POINT_W), .D(MAX_POINTS), .AW(IW)) u_pt (
      .clk   (clk),
      .we    (store_pt && (cur_sel == 1'(k))),
      .waddr (wr_idx),
      .wdata ({x_coord, y_coord, z_coord}),
      .re    (state == S_SCAN),
      .raddr ((cur_sel == 1'(k)) ? cur_addr : prv_addr),
      .rdata (pt_rd[k])
    );
    mnbt_ram #(.W(BW), .D(MAX_POINTS), .AW(IW)) u_id (
      .clk   (clk),
      .we    (out_load && (cur_sel == 1'(k))),
      .waddr (outer),
      .wdata (res_id),
      .re    ((state == S_RESOLVE) && (cur_sel != 1'(k))),
      .raddr (best_idx),
      .rdata (id_rd[k])
    );
  end

  mnbt_ram #(.W(IW), .D(MAX_POINTS), .AW(IW)) u_near (
    .clk   (clk),
    .we    (near_we),
    .waddr (outer),
    .wdata (best_idx),
    .re    (state == S_RESOLVE),
    .raddr (best_idx),
    .rdata (near_rd)
  );

  always_comb begin
    linked    = (prev_count != '0) && (near_rd == outer) && (best_d <= DIST_W'(thr));
    fresh_ovf = 1'b0;
    if (linked) begin
      res_id = id_rd[~cur_sel];
    end else if (!next_branch[BW]) begin
      res_id = next_branch[BW-1:0];
    end else begin
      res_id    = '1;
      fresh_ovf = 1'b1;
    end
    res_id_ext = {{ID_OUT_W{1'b0}}, res_id};
  end

  assign out_load = (state == S_EMIT) && (!out_valid || !out_stall);

  // Distance pipeline.
  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v0 <= (state == S_SCAN);
      v1 <= v0;
      v2 <= v1;
      v3 <= v2;
    end
    t0 <= inner;
    t1 <= t0;
    t2 <= t1;
    t3 <= t2;
    dx <= (cur_pt[47:32] > prv_pt[47:32]) ? cur_pt[47:32] - prv_pt[47:32]
                                          : prv_pt[47:32] - cur_pt[47:32];
    dy <= (cur_pt[31:16] > prv_pt[31:16]) ? cur_pt[31:16] - prv_pt[31:16]
                                          : prv_pt[31:16] - cur_pt[31:16];
    dz <= (cur_pt[15:0] > prv_pt[15:0]) ? cur_pt[15:0] - prv_pt[15:0]
                                        : prv_pt[15:0] - cur_pt[15:0];
    sx <= dx * dx;
    sy <= dy * dy;
    sz <= dz * dz;
    dsum <= DIST_W'(sx) + DIST_W'(sy) + DIST_W'(sz);
    if (v3 && ((t3 == '0) || (dsum < best_d))) begin
      best_d   <= dsum;
      best_idx <= t3;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      thr         <= THR_RESET;
      cur_sel     <= 1'b0;
      cur_count   <= '0;
      prev_count  <= '0;
      next_branch <= '0;
      dropped     <= 1'b0;
      pass2       <= 1'b0;
      outer       <= '0;
      inner       <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        thr <= cfg_data;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_acc) begin
            cur_count <= cnt_after;
            if (sweep_start) begin
              next_branch <= '0;
            end
            if (last_in_sample && (cnt_after == '0)) begin
              prev_count <= '0;
              dropped    <= 1'b0;
            end else begin
              if (sweep_start) begin
                prev_count <= '0;
              end
              dropped <= drop_next;
            end
            if (last_in_sample) begin
              outer <= '0;
              inner <= '0;
              if (cnt_after != '0) begin
                if (sweep_start || (prev_count == '0)) begin
                  pass2 <= 1'b1;
                  state <= S_RESOLVE;
                end else begin
                  pass2 <= 1'b0;
                  state <= S_SCAN;
                end
              end
            end
          end
        end
        S_SCAN: begin
          inner <= inner + IW'(1);
          if (inner_last) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (!v0 && !v1 && !v2 && !v3) begin
            inner <= '0;
            if (pass2) begin
              state <= S_RESOLVE;
            end else begin
              state <= S_SCAN;
              if (outer_last) begin
                outer <= '0;
                pass2 <= 1'b1;
              end else begin
                outer <= outer + IW'(1);
              end
            end
          end
        end
        S_RESOLVE: begin
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (out_load) begin
            point_index     <= INDEX_OUT_W'(outer);
            branch_id       <= res_id_ext[ID_OUT_W-1:0];
            new_branch      <= !linked;
            branch_overflow <= fresh_ovf;
            sample_overflow <= dropped;
            last_result     <= outer_last;
            if (!linked && !next_branch[BW]) begin
              next_branch <= next_branch + (BW+1)'(1);
            end
            inner <= '0;
            if (outer_last) begin
              cur_sel    <= ~cur_sel;
              prev_count <= cur_count;
              cur_count  <= '0;
              dropped    <= 1'b0;
              state      <= S_IDLE;
            end else begin
              outer <= outer + IW'(1);
              state <= (prev_count == '0) ? S_RESOLVE : S_SCAN;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    cur_count <= CW'(MAX_POINTS))
    else $error("current point count exceeds capacity");

  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    (out_load && outer_last) |=> (state == S_IDLE))
    else $error("matcher still busy after the final result");

  a_pipe_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |=> !v1 || $past(v0))
    else $error("distance pipeline active without a scan");

  a_emit_order: assert property (@(posedge clk) disable iff (rst)
    (out_load && !outer_last) |=> (state == S_SCAN || state == S_RESOLVE))
    else $error("matcher left the sample before its last result");

endmodule
